### sv/npcm_pkg.sv
// ----------------------------------------------------------------------------
// npcm_pkg
// Shared types and constants for the nearest palette color match block.
// ----------------------------------------------------------------------------
package npcm_pkg;

    localparam int DEFAULT_PALETTE_DEPTH = 256;

    // Largest number of entries a write can reach through an 8-bit index.
    localparam int WRITE_REACH = 256;

    localparam int DIST_W = 10;
    localparam logic [DIST_W-1:0] EMPTY_DISTANCE = 10'd1023;

    // One RGB color, red in the upper byte as stored in the palette.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_MATCH = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

endpackage

### sv/npcm_l1_unit.sv
// ----------------------------------------------------------------------------
// npcm_l1_unit
// Shared distance unit: L1 RGB distance and compare against the current best.
// ----------------------------------------------------------------------------
module npcm_l1_unit (
    input  npcm_pkg::rgb_t                   pixel,
    input  npcm_pkg::rgb_t                   entry,
    input  logic [npcm_pkg::DIST_W-1:0]      best_distance,
    output logic [npcm_pkg::DIST_W-1:0]      distance,
    output logic                             closer
);
    import npcm_pkg::*;

    logic [7:0] diff_red;
    logic [7:0] diff_green;
    logic [7:0] diff_blue;

    assign diff_red   = (pixel.red > entry.red) ? (pixel.red - entry.red)
                                                : (entry.red - pixel.red);
    assign diff_green = (pixel.green > entry.green) ? (pixel.green - entry.green)
                                                    : (entry.green - pixel.green);
    assign diff_blue  = (pixel.blue > entry.blue) ? (pixel.blue - entry.blue)
                                                  : (entry.blue - pixel.blue);

    assign distance = DIST_W'(diff_red) + DIST_W'(diff_green) + DIST_W'(diff_blue);

    // Strictly smaller, so the first entry wins a tie.
    assign closer = (distance < best_distance);

endmodule

### sv/nearest_palette_color_match.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_match
// Palette table with an iterative L1 nearest-color search.
// ----------------------------------------------------------------------------
//  channel   | signals                          | contents
//  ----------+----------------------------------+-------------------------------
//  input     | s_axis_tvalid/tready/tdata/tuser | write entry or match pixel
//  result    | m_axis_tvalid/tready/tdata       | best index and distance
//  config    | cfg_wr_en, cfg_wr_data           | palette_count
//
//  A match scans palette_count entries, capped at the table size and at
//  WRITE_REACH: the scan reads one entry per cycle from the single read port
//  of the palette memory, and each read feeds the one distance unit in the
//  next cycle. An empty palette skips the scan and goes straight to the final
//  state. Reset clears the sequencer, the result register and palette_count;
//  the palette contents are undefined until written. A finished search waits
//  in the final state while an earlier result is still stalled in the output
//  register, and no new transaction is taken until that result drains.
// ----------------------------------------------------------------------------
module nearest_palette_color_match #(
    parameter int PALETTE_DEPTH = npcm_pkg::DEFAULT_PALETTE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // entry_index, red, green, blue
    input  logic        s_axis_tuser,   // operation

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // best_index, best_distance, zero fill

    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data     // palette_count
);
    import npcm_pkg::*;

    localparam int AW       = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int SCAN_MAX = (PALETTE_DEPTH < WRITE_REACH) ? PALETTE_DEPTH : WRITE_REACH;
    localparam int SW       = (SCAN_MAX > 1) ? $clog2(SCAN_MAX) : 1;

    // Input fields
    logic [7:0] in_entry_index;
    rgb_t       in_color;
    op_t        in_op;
    logic       in_accept;

    assign in_entry_index = s_axis_tdata[7:0];
    assign in_color.red   = s_axis_tdata[15:8];
    assign in_color.green = s_axis_tdata[23:16];
    assign in_color.blue  = s_axis_tdata[31:24];
    assign in_op          = op_t'(s_axis_tuser);

    // Registers
    state_t            state_reg, state_next;
    logic [8:0]        cfg_count_reg;
    rgb_t              pixel_reg;
    logic [SW-1:0]     scan_idx_reg;
    logic [SW-1:0]     last_reg;
    logic              issue_reg;
    logic              rd_valid_reg;
    logic              rd_last_reg;
    logic [SW-1:0]     rd_idx_reg;
    rgb_t              rd_data_reg;
    logic [DIST_W-1:0] best_dist_reg;
    logic [SW-1:0]     best_idx_reg;
    logic              out_valid_reg;
    logic [7:0]        out_index_reg;
    logic [DIST_W-1:0] out_dist_reg;

    rgb_t palette_mem [PALETTE_DEPTH];

    // Distance unit
    logic [DIST_W-1:0] cand_dist;
    logic              cand_closer;

    npcm_l1_unit u_l1 (
        .pixel         (pixel_reg),
        .entry         (rd_data_reg),
        .best_distance (best_dist_reg),
        .distance      (cand_dist),
        .closer        (cand_closer)
    );

    logic       out_free;
    logic [8:0] limit;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign limit         = (cfg_count_reg > 9'(SCAN_MAX)) ? 9'(SCAN_MAX) : cfg_count_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && in_op == OP_MATCH)
                begin
                    state_next = (limit == 9'd0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (rd_valid_reg && rd_last_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cfg_count_reg <= 9'd0;
            issue_reg     <= 1'b0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                cfg_count_reg <= cfg_wr_data;
            end

            if (state_reg == S_IDLE && in_accept && in_op == OP_MATCH && limit != 9'd0)
            begin
                issue_reg <= 1'b1;
            end
            else if (issue_reg && scan_idx_reg == last_reg)
            begin
                issue_reg <= 1'b0;
            end
            rd_valid_reg <= issue_reg;

            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Scan datapath and result payload
    always_ff @(posedge clk)
    begin
        if (in_accept && in_op == OP_MATCH)
        begin
            pixel_reg     <= in_color;
            scan_idx_reg  <= '0;
            last_reg      <= SW'(limit - 9'd1);
            best_dist_reg <= EMPTY_DISTANCE;
            best_idx_reg  <= '0;
        end
        else
        begin
            if (issue_reg)
            begin
                scan_idx_reg <= scan_idx_reg + SW'(1);
            end
            if (rd_valid_reg && cand_closer)
            begin
                best_dist_reg <= cand_dist;
                best_idx_reg  <= rd_idx_reg;
            end
        end

        rd_idx_reg  <= scan_idx_reg;
        rd_last_reg <= (scan_idx_reg == last_reg);

        if (state_reg == S_DONE && out_free)
        begin
            out_index_reg <= 8'(best_idx_reg);
            out_dist_reg  <= best_dist_reg;
        end
    end

    // Palette memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (in_accept && in_op == OP_WRITE
            && 32'(in_entry_index) < 32'(PALETTE_DEPTH))
        begin
            palette_mem[AW'(in_entry_index)] <= in_color;
        end
        if (issue_reg)
        begin
            rd_data_reg <= palette_mem[AW'(scan_idx_reg)];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_dist_reg, out_index_reg};

    // Assertions
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == S_DONE))
        else $error("result appeared without a finished search");

    a_distance_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[17:8] <= 10'd765)
                          || (m_axis_tdata[17:8] == EMPTY_DISTANCE && m_axis_tdata[7:0] == 8'd0))
        else $error("result distance out of range");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        issue_reg |-> (state_reg == S_SCAN) && (scan_idx_reg <= last_reg))
        else $error("scan read past the palette count");

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> state_reg == S_SCAN)
        else $error("entry compared outside a scan");

endmodule

### tb/sv/nearest_palette_color_match_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color_match_tb
// Loads palettes of several sizes, streams writes and match pixels through the
// block under random sender gaps and receiver stalls, and checks every match
// result against a nearest-color search kept in the testbench.
// ----------------------------------------------------------------------------
module nearest_palette_color_match_tb;
    import npcm_pkg::*;

    localparam int PALETTE_DEPTH  = DEFAULT_PALETTE_DEPTH;
    localparam int ITEM_TARGET    = 1400;
    // Settling time that covers a full-palette match, with a margin on top.
    localparam int SETTLE_CYCLES  = PALETTE_DEPTH + 8;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam int READY_ALWAYS = 0;
    localparam int READY_COIN   = 1;
    localparam int READY_SPARSE = 2;

    typedef struct packed {
        logic [7:0] index;
        logic [9:0] distance;
    } match_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tuser = OP_WRITE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [8:0]  cfg_wr_data = '0;

    rgb_t        palette_colors [PALETTE_DEPTH];
    logic [8:0]  search_count = '0;
    match_t      expected_matches [$];
    match_t      oldest_match;
    int          error_count = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    int          ready_mode = READY_ALWAYS;
    int          ready_mode_left = 0;

    nearest_palette_color_match #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #10 clk = ~clk;

    function automatic logic [9:0] channel_gap(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? 10'(a - b) : 10'(b - a);
    endfunction

    // First entry with the smallest L1 distance; an empty search keeps the start value.
    function automatic match_t find_nearest(input rgb_t pixel);
        match_t      best;
        int unsigned reach;
        logic [9:0]  gap_sum;
        reach = search_count;
        if (reach > PALETTE_DEPTH)
            reach = PALETTE_DEPTH;
        if (reach > WRITE_REACH)
            reach = WRITE_REACH;
        best.index    = '0;
        best.distance = EMPTY_DISTANCE;
        for (int i = 0; i < reach; i++)
        begin
            gap_sum = channel_gap(palette_colors[i].red, pixel.red)
                    + channel_gap(palette_colors[i].green, pixel.green)
                    + channel_gap(palette_colors[i].blue, pixel.blue);
            if (gap_sum < best.distance)
            begin
                best.index    = 8'(i);
                best.distance = gap_sum;
            end
        end
        return best;
    endfunction

    // Coarse colors land on few distinct values, which makes ties common.
    function automatic rgb_t random_color(input bit coarse);
        rgb_t c;
        c = 24'($urandom);
        if (coarse)
        begin
            c.red   = 8'($urandom_range(0, 3) * 64);
            c.green = 8'($urandom_range(0, 3) * 64);
            c.blue  = 8'($urandom_range(0, 3) * 64);
        end
        return c;
    endfunction

    task automatic send_item(input op_t op, input logic [7:0] entry, input rgb_t color);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {color.blue, color.green, color.red, entry};
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        if (op == OP_WRITE)
        begin
            if (entry < PALETTE_DEPTH)
                palette_colors[entry] = color;
        end
        else
            expected_matches = {expected_matches, find_nearest(color)};
    endtask

    task automatic write_entry(input logic [7:0] entry, input rgb_t color);
        send_item(OP_WRITE, entry, color);
    endtask

    task automatic match_pixel(input rgb_t pixel);
        send_item(OP_MATCH, 8'($urandom), pixel);
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_matches.size() != 0)
            @(posedge clk);
    endtask

    task automatic program_palette_count(input logic [8:0] count);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        search_count = count;
    endtask

    task automatic test_empty_palette();
        program_palette_count(9'd0);
        match_pixel('{8'd0, 8'd0, 8'd0});
        write_entry(8'd7, '{8'd10, 8'd20, 8'd30});
        send_item(OP_MATCH, 8'd255, '{8'd255, 8'd255, 8'd255});
    endtask

    task automatic test_extremes();
        program_palette_count(9'd1);
        write_entry(8'd0, '{8'd0, 8'd0, 8'd0});
        write_entry(8'd1, '{8'd255, 8'd255, 8'd255});
        match_pixel('{8'd255, 8'd255, 8'd255});
        match_pixel('{8'd0, 8'd0, 8'd0});
        program_palette_count(9'd2);
        match_pixel('{8'd255, 8'd255, 8'd255});
        match_pixel('{8'd0, 8'd255, 8'd0});
        match_pixel('{8'd128, 8'd128, 8'd128});
    endtask

    task automatic test_tie_break();
        program_palette_count(9'd4);
        write_entry(8'd0, '{8'd200, 8'd200, 8'd200});
        write_entry(8'd1, '{8'd10, 8'd20, 8'd30});
        write_entry(8'd2, '{8'd100, 8'd0, 8'd0});
        write_entry(8'd3, '{8'd10, 8'd20, 8'd30});
        match_pixel('{8'd10, 8'd20, 8'd30});
        match_pixel('{8'd12, 8'd20, 8'd30});
        // Different colors at the same distance: the lower index must win.
        write_entry(8'd0, '{8'd14, 8'd20, 8'd30});
        match_pixel('{8'd12, 8'd20, 8'd30});
    endtask

    task automatic test_full_palette();
        rgb_t color;
        program_palette_count(9'(PALETTE_DEPTH));
        for (int i = 0; i < PALETTE_DEPTH - 1; i++)
        begin
            color = random_color(1'b0);
            color.red[7] = 1'b0;
            write_entry(8'(i), color);
        end
        write_entry(8'(PALETTE_DEPTH - 1), '{8'd255, 8'd255, 8'd255});
        match_pixel('{8'd255, 8'd255, 8'd255});
        match_pixel('{8'd0, 8'd0, 8'd0});
        repeat (6) match_pixel(random_color(1'b0));
    endtask

    task automatic test_random_traffic();
        int   count;
        int   pick;
        bit   coarse;
        rgb_t pixel;
        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                count = 0;
            else if (pick == 1)
                count = PALETTE_DEPTH;
            else if (pick == 2)
                count = 1;
            else
                count = $urandom_range(2, 24);
            coarse = 1'($urandom_range(0, 1));
            program_palette_count(9'(count));
            for (int i = 0; i < count; i++)
                write_entry(8'(i), random_color(coarse));
            repeat ($urandom_range(20, 60))
            begin
                if ($urandom_range(0, 3) == 0)
                    write_entry(8'($urandom), random_color(coarse));
                else
                begin
                    case ($urandom_range(0, 3))
                        0: pixel = random_color(1'b0);
                        1: pixel = palette_colors[$urandom_range(0, (count > 0) ? count - 1 : 0)];
                        2: pixel = '{8'($urandom_range(0, 1) * 255),
                                     8'($urandom_range(0, 1) * 255),
                                     8'($urandom_range(0, 1) * 255)};
                        default: pixel = random_color(1'b1);
                    endcase
                    match_pixel(pixel);
                end
                if ($urandom_range(0, 24) == 0)
                    wait_for_results();
            end
        end
    endtask

    // Receiver: stretches of always-ready, coin-flip and mostly-stalled behavior.
    always @(posedge clk)
    begin
        if (ready_mode_left == 0)
        begin
            ready_mode      = $urandom_range(READY_ALWAYS, READY_SPARSE);
            ready_mode_left = $urandom_range(10, 120);
        end
        ready_mode_left--;
        case (ready_mode)
            READY_ALWAYS: m_axis_tready <= 1'b1;
            READY_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
            default:      m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_matches.size() == 0)
            begin
                $error("Unexpected result transaction: best_index %0d best_distance %0d",
                       m_axis_tdata[7:0], m_axis_tdata[17:8]);
                error_count++;
            end
            else
            begin
                oldest_match = expected_matches.pop_front();
                if (m_axis_tdata[7:0] !== oldest_match.index)
                begin
                    $error("best_index mismatch: expected %0d, actual %0d",
                           oldest_match.index, m_axis_tdata[7:0]);
                    error_count++;
                end
                if (m_axis_tdata[17:8] !== oldest_match.distance)
                begin
                    $error("best_distance mismatch: expected %0d, actual %0d",
                           oldest_match.distance, m_axis_tdata[17:8]);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_palette();
        test_extremes();
        test_tie_break();
        test_full_palette();
        test_random_traffic();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
